// ----- rtl/spbs_pkg.sv -----
// Shared types and constants for the soft power button sequencer.
package spbs_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned CfgIdxW = 4;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  localparam logic [CountW-1:0] ConfirmTimeoutRst = 16'd850;
  localparam logic [CountW-1:0] PressOnRst = 16'd85;
  localparam logic [CountW-1:0] PressOffRst = 16'd340;
  localparam logic [CountW-1:0] SettleRst = 16'd255;

  localparam logic [CfgIdxW-1:0] RegConfirmTimeout = 4'd0;
  localparam logic [CfgIdxW-1:0] RegPressOn = 4'd1;
  localparam logic [CfgIdxW-1:0] RegPressOff = 4'd2;
  localparam logic [CfgIdxW-1:0] RegSettle = 4'd3;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_ON     = 2'd1,
    MODE_SETTLE = 2'd2,
    MODE_SLEEP  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [CountW-1:0] confirm_timeout_ticks;
    logic [CountW-1:0] press_on_ticks;
    logic [CountW-1:0] press_off_ticks;
    logic [CountW-1:0] settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic  power_enable;
    logic  cpu_button_drive;
    mode_t mode_now;
  } result_t;

endpackage

// ----- rtl/spbs_cfg.sv -----
// Configuration register file for the soft power button sequencer.
module spbs_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [spbs_pkg::CfgIdxW-1:0]  cfg_addr,
  input  logic [spbs_pkg::CountW-1:0]   cfg_wdata,
  output spbs_pkg::cfg_t                cfg
);

  spbs_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.confirm_timeout_ticks <= spbs_pkg::ConfirmTimeoutRst;
      cfg_r.press_on_ticks        <= spbs_pkg::PressOnRst;
      cfg_r.press_off_ticks       <= spbs_pkg::PressOffRst;
      cfg_r.settle_ticks          <= spbs_pkg::SettleRst;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        spbs_pkg::RegConfirmTimeout: cfg_r.confirm_timeout_ticks <= cfg_wdata;
        spbs_pkg::RegPressOn:        cfg_r.press_on_ticks        <= cfg_wdata;
        spbs_pkg::RegPressOff:       cfg_r.press_off_ticks       <= cfg_wdata;
        spbs_pkg::RegSettle:         cfg_r.settle_ticks          <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/spbs_core.sv -----
// Sequencer state and per-tick next-state logic.
module spbs_core (
  input  logic                clk,
  input  logic                rst_n,
  input  spbs_pkg::cfg_t      cfg,
  input  logic                step,
  input  logic                button_pressed,
  input  logic                cpu_request,
  output spbs_pkg::result_t   result
);

  spbs_pkg::mode_t              mode_r, mode_nxt;
  logic [spbs_pkg::CountW-1:0]  press_r, press_nxt;
  logic [spbs_pkg::CountW-1:0]  phase_r, phase_nxt;
  logic                         power_r, power_nxt;
  logic                         drive_r, drive_nxt;
  logic [1:0]                   prev_r, prev_nxt;

  logic [1:0]                   levels;
  logic [spbs_pkg::CountW-1:0]  press_inc;
  logic [spbs_pkg::CountW-1:0]  phase_inc;

  always_comb begin
    levels    = {cpu_request, button_pressed};
    press_inc = !button_pressed ? '0 :
                (press_r == spbs_pkg::CountMax) ? press_r : press_r + 1'b1;
    phase_inc = (phase_r == spbs_pkg::CountMax) ? phase_r : phase_r + 1'b1;

    mode_nxt  = mode_r;
    press_nxt = press_r;
    phase_nxt = phase_r;
    power_nxt = power_r;
    drive_nxt = drive_r;
    prev_nxt  = prev_r;

    case (mode_r)
      spbs_pkg::MODE_SLEEP: begin
        if (levels != prev_r) begin
          mode_nxt  = spbs_pkg::MODE_OFF;
          press_nxt = '0;
          phase_nxt = '0;
          power_nxt = 1'b0;
          drive_nxt = 1'b0;
          prev_nxt  = '0;
        end
      end
      spbs_pkg::MODE_OFF: begin
        press_nxt = press_inc;
        phase_nxt = phase_inc;
        if (phase_inc > cfg.confirm_timeout_ticks) begin
          power_nxt = 1'b0;
          mode_nxt  = spbs_pkg::MODE_SETTLE;
        end
        if (press_inc > cfg.press_on_ticks) begin
          power_nxt = 1'b1;
          phase_nxt = '0;
        end
        if (cpu_request) begin
          power_nxt = 1'b1;
          mode_nxt  = spbs_pkg::MODE_ON;
        end
      end
      spbs_pkg::MODE_ON: begin
        press_nxt = press_inc;
        phase_nxt = phase_inc;
        if (!cpu_request || (press_inc > cfg.press_off_ticks)) begin
          power_nxt = 1'b0;
          drive_nxt = 1'b0;
          phase_nxt = '0;
          mode_nxt  = spbs_pkg::MODE_SETTLE;
        end else begin
          drive_nxt = (press_inc != '0);
        end
      end
      default: begin
        press_nxt = press_inc;
        phase_nxt = phase_inc;
        if (phase_inc > cfg.settle_ticks) begin
          mode_nxt = spbs_pkg::MODE_SLEEP;
          prev_nxt = levels;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= spbs_pkg::MODE_OFF;
      press_r <= '0;
      phase_r <= '0;
      power_r <= 1'b0;
      drive_r <= 1'b0;
      prev_r  <= '0;
    end else if (step) begin
      mode_r  <= mode_nxt;
      press_r <= press_nxt;
      phase_r <= phase_nxt;
      power_r <= power_nxt;
      drive_r <= drive_nxt;
      prev_r  <= prev_nxt;
    end
  end

  assign result.power_enable     = power_nxt;
  assign result.cpu_button_drive = drive_nxt;
  assign result.mode_now         = mode_nxt;

endmodule

// ----- rtl/soft_power_button_sequencer.sv -----
// Soft power button sequencer: input word register, sequencer core, result register.
// An accepted word waits in the input register; its result is held in the result register.
// Throughput: one word per cycle; the input register drains straight into the
// result register whenever that register is empty or being taken.
// Reset (rst_n, synchronous, active low): mode off, counters, flags and out_tvalid clear,
// configuration registers return to their default values.
module soft_power_button_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [0] button_pressed, [1] cpu_request
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [0] power_enable, [1] cpu_button_drive,
                                                    // [3:2] mode_now
  input  logic                          cfg_wr_en,
  input  logic [spbs_pkg::CfgIdxW-1:0]  cfg_addr,
  input  logic [spbs_pkg::CountW-1:0]   cfg_wdata
);

  spbs_pkg::cfg_t     cfg;
  spbs_pkg::result_t  result;
  spbs_pkg::result_t  res_r;

  logic       in_valid_r;
  logic [1:0] in_levels_r;
  logic       out_valid_r;
  logic       adv;

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  spbs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  spbs_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .step           (adv),
    .button_pressed (in_levels_r[0]),
    .cpu_request    (in_levels_r[1]),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_levels_r <= in_tdata[1:0];
    end
    if (adv) begin
      res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, res_r.mode_now, res_r.cpu_button_drive, res_r.power_enable};

`ifndef SYNTH
  // on mode always has the supply enabled
  a_on_powered: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.mode_now == spbs_pkg::MODE_ON)) |-> res_r.power_enable)
    else $error("on mode without power");

  // the CPU button line is only driven while on
  a_drive_on_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.cpu_button_drive) |-> (res_r.mode_now == spbs_pkg::MODE_ON))
    else $error("drive outside on mode");

  // a stepped word always lands in the result register
  a_adv_lands: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("result word lost");

  // a held input word is not dropped while the result side stalls
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !adv) |=> (in_valid_r && $stable(in_levels_r)))
    else $error("input word dropped");
`endif

endmodule

// ----- verif/spbs_sequence_checker.sv -----
// Checker for the soft power button sequencer: predicts each result word and compares it.
`timescale 1ns / 100ps
module spbs_sequence_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  input  logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [0] button_pressed, [1] cpu_request
  input  logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic [7:0]                   out_tdata,  // [0] power_enable, [1] cpu_button_drive,
                                                   // [3:2] mode_now
  input  logic                         cfg_wr_en,
  input  logic [spbs_pkg::CfgIdxW-1:0] cfg_addr,
  input  logic [spbs_pkg::CountW-1:0]  cfg_wdata,
  output int                           fail_count,
  output int                           waiting_count
);
  import spbs_pkg::*;

  cfg_t              thresholds;
  mode_t             cur_mode;
  logic [CountW-1:0] held_ticks;
  logic [CountW-1:0] phase_ticks;
  logic              supply_on;
  logic              drive_low;
  logic [1:0]        sleep_levels;
  result_t           expected_words[$];

  task automatic clear_sequencer();
    cur_mode     = MODE_OFF;
    held_ticks   = '0;
    phase_ticks  = '0;
    supply_on    = 1'b0;
    drive_low    = 1'b0;
    sleep_levels = '0;
  endtask

  task automatic poll_tick(input logic btn, input logic req, output result_t word);
    logic [1:0] levels;
    levels = {req, btn};
    if (cur_mode == MODE_SLEEP) begin
      if (levels != sleep_levels) clear_sequencer();
    end else begin
      if (!btn) held_ticks = '0;
      else if (held_ticks != CountMax) held_ticks = held_ticks + 1'b1;
      if (phase_ticks != CountMax) phase_ticks = phase_ticks + 1'b1;
      case (cur_mode)
        MODE_OFF: begin
          // timeout leaves phase_ticks alone; a press on the same tick powers up again
          if (phase_ticks > thresholds.confirm_timeout_ticks) begin
            supply_on = 1'b0;
            cur_mode  = MODE_SETTLE;
          end
          if (held_ticks > thresholds.press_on_ticks) begin
            supply_on   = 1'b1;
            phase_ticks = '0;
          end
          if (req) begin
            supply_on = 1'b1;
            cur_mode  = MODE_ON;
          end
        end
        MODE_ON: begin
          if (!req || held_ticks > thresholds.press_off_ticks) begin
            supply_on   = 1'b0;
            drive_low   = 1'b0;
            phase_ticks = '0;
            cur_mode    = MODE_SETTLE;
          end else begin
            drive_low = (held_ticks != '0);
          end
        end
        default: begin
          if (phase_ticks > thresholds.settle_ticks) begin
            cur_mode     = MODE_SLEEP;
            sleep_levels = levels;
          end
        end
      endcase
    end
    word.power_enable     = supply_on;
    word.cpu_button_drive = drive_low;
    word.mode_now         = cur_mode;
  endtask

  task automatic report(input string want_text, input logic [7:0] seen);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: got power %b drive %b mode %0d (word %h), %s", $time,
               seen[0], seen[1], seen[3:2], seen, want_text);
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t word;
    if (!rst_n) begin
      thresholds = '{ConfirmTimeoutRst, PressOnRst, PressOffRst, SettleRst};
      clear_sequencer();
      expected_words.delete();
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          report("no word expected", out_tdata);
        end else begin
          want = expected_words.pop_front();
          if (out_tdata[0] !== want.power_enable || out_tdata[1] !== want.cpu_button_drive ||
              out_tdata[3:2] !== want.mode_now || out_tdata[7:4] !== 4'b0000)
            report($sformatf("expected power %b drive %b mode %0d", want.power_enable,
                             want.cpu_button_drive, want.mode_now), out_tdata);
        end
      end
      if (cfg_wr_en) begin
        case (cfg_addr)
          RegConfirmTimeout: thresholds.confirm_timeout_ticks = cfg_wdata;
          RegPressOn:        thresholds.press_on_ticks = cfg_wdata;
          RegPressOff:       thresholds.press_off_ticks = cfg_wdata;
          RegSettle:         thresholds.settle_ticks = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        poll_tick(in_tdata[0], in_tdata[1], word);
        expected_words.push_back(word);
      end
    end
    waiting_count = expected_words.size();
  end

endmodule

// ----- verif/tb_soft_power_button_sequencer.sv -----
// Testbench top for the soft power button sequencer: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module tb_soft_power_button_sequencer;
  import spbs_pkg::*;

  localparam int WatchdogCycles = 1_000_000;
  localparam int RandItems      = 1500;
  localparam int HoldCycles     = 300;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [7:0]         in_tdata = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [7:0]         out_tdata;
  logic               cfg_wr_en = 1'b0;
  logic [CfgIdxW-1:0] cfg_addr = '0;
  logic [CountW-1:0]  cfg_wdata = '0;

  int    fail_count;
  int    waiting_count;
  int    tx_idle_pct = 0;
  int    rx_idle_pct = 0;
  int    hold_asks = 0;
  int    hold_done = 0;
  int    hold_left = 0;
  int    n_sent = 0;
  int    n_got = 0;
  int    cycle_count = 0;
  mode_t last_mode = MODE_OFF;

  soft_power_button_sequencer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  spbs_sequence_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .waiting_count (waiting_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_done != hold_asks) begin
      hold_done  <= hold_asks;
      hold_left  <= HoldCycles;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_tvalid && out_tready) begin
      n_got     <= n_got + 1;
      last_mode <= mode_t'(out_tdata[3:2]);
    end
  end

  initial begin
    while (cycle_count < WatchdogCycles) @(posedge clk);
    $display("tb_soft_power_button_sequencer: done, errors");
    $finish;
  end

  task automatic set_idling(input int sel);
    case (sel)
      0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      1: begin tx_idle_pct = 46; rx_idle_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_idle_pct = 46; end
      default: begin tx_idle_pct = 33; rx_idle_pct = 33; end
    endcase
  endtask

  task automatic send_word(input logic btn, input logic req);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, req, btn};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (n_got != n_sent) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_load(input logic [CountW-1:0] timeout_v, input logic [CountW-1:0] on_v,
                          input logic [CountW-1:0] off_v, input logic [CountW-1:0] settle_v);
    logic [CfgIdxW-1:0] stray;
    stray = CfgIdxW'($urandom_range((1 << CfgIdxW) - 1, RegSettle + 1));
    drain();
    cfg_wr_en <= 1'b1;
    cfg_addr  <= RegConfirmTimeout;
    cfg_wdata <= timeout_v;
    @(posedge clk);
    cfg_addr  <= RegPressOn;
    cfg_wdata <= on_v;
    @(posedge clk);
    cfg_addr  <= RegPressOff;
    cfg_wdata <= off_v;
    @(posedge clk);
    cfg_addr  <= RegSettle;
    cfg_wdata <= settle_v;
    @(posedge clk);
    // unmapped index, must be ignored
    cfg_addr  <= stray;
    cfg_wdata <= CountW'($urandom);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // walk the block into sleep with both levels low, then wake it: off, all clear
  task automatic rest_state();
    cfg_load('0, CountMax, '0, '0);
    do begin
      send_word(1'b0, 1'b0);
      drain();
    end while (last_mode != MODE_SLEEP);
    send_word(1'b1, 1'b0);
    drain();
  endtask

  function automatic logic [CountW-1:0] pick_threshold();
    logic [CountW-1:0] v;
    case ($urandom_range(9))
      0: v = '0;
      1: v = CountMax;
      2: v = CountW'($urandom);
      default: v = CountW'($urandom_range(12, 1));
    endcase
    return v;
  endfunction

  initial begin
    // {cpu_request, button_pressed}
    logic [1:0] script [21] = '{
      2'b01, 2'b01, 2'b01, 2'b11, 2'b11, 2'b00, 2'b00, 2'b00, 2'b10,
      2'b00, 2'b01, 2'b01, 2'b01, 2'b01, 2'b01, 2'b01, 2'b11,
      2'b10, 2'b11, 2'b10, 2'b00
    };
    int         n_rand;
    int         phase_no;
    int         phase_len;
    int         run_len;
    int         cnt;
    logic [1:0] lv;

    n_rand   = 0;
    phase_no = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // press-on, confirm, long press off, sleep, wake, press on the timeout tick
    cfg_load(16'd3, 16'd2, 16'd2, 16'd1);
    foreach (script[i]) send_word(script[i][0], script[i][1]);

    // sleep with both levels low, then wake back into a clear off state
    rest_state();

    while (n_rand < RandItems) begin
      set_idling(phase_no % 4);
      cfg_load(pick_threshold(), pick_threshold(), pick_threshold(), pick_threshold());
      if (phase_no % 4 == 0 && phase_no < 12) hold_asks++;
      phase_len = $urandom_range(160, 60);
      cnt = 0;
      while (cnt < phase_len) begin
        lv = 2'($urandom_range(3));
        run_len = ($urandom_range(4) != 0) ? $urandom_range(25, 1) : 1;
        repeat (run_len) begin
          send_word(lv[0], lv[1]);
          cnt++;
        end
      end
      n_rand += cnt;
      phase_no++;
    end

    drain();
    $display("Covered %0d words: directed mode walk, sleep and wake, %0d random words",
             n_sent, n_rand);
    $display("over %0d threshold sets and idling mixes; %0d mismatches, %0d words outstanding",
             phase_no, fail_count, waiting_count);
    if (fail_count == 0 && waiting_count == 0)
      $display("tb_soft_power_button_sequencer: done, clean");
    else
      $display("tb_soft_power_button_sequencer: done, errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/spbs_pkg.sv
rtl/spbs_cfg.sv
rtl/spbs_core.sv
rtl/soft_power_button_sequencer.sv
verif/spbs_sequence_checker.sv
verif/tb_soft_power_button_sequencer.sv
